@@ rtl/core/u8u16_pkg.sv @@
// Shared types and constants for the UTF-8 to basic-plane UTF-16 decoder.
package u8u16_pkg;

  localparam int unsigned AccumW   = 31;
  localparam int unsigned PendingW = 3;
  localparam int unsigned UnitW    = 16;

  // Lead byte class masks and match patterns
  localparam logic [7:0] Lead2Mask = 8'hE0;
  localparam logic [7:0] Lead2Pat  = 8'hC0;
  localparam logic [7:0] Lead3Mask = 8'hF0;
  localparam logic [7:0] Lead3Pat  = 8'hE0;
  localparam logic [7:0] Lead4Mask = 8'hF8;
  localparam logic [7:0] Lead4Pat  = 8'hF0;
  localparam logic [7:0] Lead5Mask = 8'hFC;
  localparam logic [7:0] Lead5Pat  = 8'hF8;
  localparam logic [7:0] Lead6Mask = 8'hFE;
  localparam logic [7:0] Lead6Pat  = 8'hFC;
  localparam logic [7:0] ContMask  = 8'h3F;

  // Surrogate range 0xD800..0xDFFF shares these top five bits
  localparam logic [4:0] SurrogateTop = 5'b11011;

  typedef struct packed {
    logic [PendingW-1:0] bytes_pending;
    logic [AccumW-1:0]   code_accum;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       is_final;
  } byte_word_t;

  typedef struct packed {
    logic [UnitW-1:0] code_unit;
    logic             unit_valid;
    logic             end_of_string;
  } unit_word_t;

endpackage

@@ rtl/core/u8u16_byte_if.sv @@
// Byte input channel: valid/ready handshake with one UTF-8 byte per word.
interface u8u16_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       is_final;

  modport source (output valid, output in_byte, output is_final, input ready);
  modport sink   (input valid, input in_byte, input is_final, output ready);
endinterface

@@ rtl/core/u8u16_unit_if.sv @@
// Result channel: valid/ready handshake carrying one UTF-16 unit word.
interface u8u16_unit_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        unit_valid;
  logic        end_of_string;

  modport source (output valid, output code_unit, output unit_valid, output end_of_string,
                  input ready);
  modport sink   (input valid, input code_unit, input unit_valid, input end_of_string,
                  output ready);
endinterface

@@ rtl/core/u8u16_step.sv @@
// Single-byte decode step: next sequence state and the result word for one byte.
module u8u16_step (
  input  u8u16_pkg::dec_state_t state_i,
  input  u8u16_pkg::byte_word_t word_i,
  output u8u16_pkg::dec_state_t state_o,
  output u8u16_pkg::unit_word_t result_o,
  output logic                  emit_o
);

  logic [7:0]                       b;
  logic                             done;
  logic                             in_bmp;
  logic                             valid;
  u8u16_pkg::dec_state_t            nxt;

  assign b = word_i.in_byte;

  always_comb begin
    nxt  = '0;
    done = 1'b0;
    if (state_i.bytes_pending != '0) begin
      // continuation: low six bits taken with no marker check
      nxt.code_accum    = {state_i.code_accum[u8u16_pkg::AccumW-7:0],
                           b[5:0] & u8u16_pkg::ContMask[5:0]};
      nxt.bytes_pending = state_i.bytes_pending - 3'd1;
      done              = (state_i.bytes_pending == 3'd1);
    end else if (b[7] == 1'b0) begin
      nxt.code_accum = {23'd0, b};
      done           = 1'b1;
    end else if ((b & u8u16_pkg::Lead2Mask) == u8u16_pkg::Lead2Pat) begin
      nxt.code_accum    = {26'd0, b[4:0]};
      nxt.bytes_pending = 3'd1;
    end else if ((b & u8u16_pkg::Lead3Mask) == u8u16_pkg::Lead3Pat) begin
      nxt.code_accum    = {27'd0, b[3:0]};
      nxt.bytes_pending = 3'd2;
    end else if ((b & u8u16_pkg::Lead4Mask) == u8u16_pkg::Lead4Pat) begin
      nxt.code_accum    = {28'd0, b[2:0]};
      nxt.bytes_pending = 3'd3;
    end else if ((b & u8u16_pkg::Lead5Mask) == u8u16_pkg::Lead5Pat) begin
      nxt.code_accum    = {29'd0, b[1:0]};
      nxt.bytes_pending = 3'd4;
    end else if ((b & u8u16_pkg::Lead6Mask) == u8u16_pkg::Lead6Pat) begin
      nxt.code_accum    = {30'd0, b[0]};
      nxt.bytes_pending = 3'd5;
    end
    // stray continuation or 0xFE/0xFF as lead: dropped, state cleared
  end

  assign in_bmp = (nxt.code_accum[u8u16_pkg::AccumW-1:u8u16_pkg::UnitW] == '0) &&
                  (nxt.code_accum[15:11] != u8u16_pkg::SurrogateTop);
  assign valid  = done && in_bmp;

  always_comb begin
    result_o.code_unit     = valid ? nxt.code_accum[u8u16_pkg::UnitW-1:0] : '0;
    result_o.unit_valid    = valid;
    result_o.end_of_string = word_i.is_final;
  end

  // end of string discards any open sequence
  assign state_o = word_i.is_final ? '0 : nxt;
  assign emit_o  = valid || word_i.is_final;

endmodule

@@ rtl/core/utf8_to_bmp_utf16_decoder_core.sv @@
// UTF-8 to basic-plane UTF-16 decoder, top level.
// Takes one byte per cycle unless a word stalls at the output, and returns at most one
// 16-bit unit word per byte. A byte is captured in an input register, decoded against the
// sequence state in one pass of short logic, and a word that carries a unit or the
// end-of-string mark is loaded into the output register. Bytes that produce no word
// never occupy the output register, and a new byte is taken while a finished word waits
// if the input register is empty or holds a byte that produces no word. Code points above
// 0xFFFF and surrogates are dropped; 5- and 6-byte legacy forms are decoded.
module utf8_to_bmp_utf16_decoder_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  u8u16_byte_if.sink         in_i,
  u8u16_unit_if.source       out_o
);

  logic                  s1_valid_q;
  u8u16_pkg::byte_word_t s1_q;
  u8u16_pkg::dec_state_t state_q, state_d;
  u8u16_pkg::unit_word_t step_res;
  logic                  step_emit;
  logic                  out_valid_q;
  u8u16_pkg::unit_word_t out_q;
  logic                  out_room;
  logic                  s1_adv;
  logic                  in_take;
  logic                  out_load;

  u8u16_step u_step (
    .state_i  (state_q),
    .word_i   (s1_q),
    .state_o  (state_d),
    .result_o (step_res),
    .emit_o   (step_emit)
  );

  assign out_room = !out_valid_q || out_o.ready;
  assign s1_adv   = s1_valid_q && (!step_emit || out_room);
  assign out_load = s1_adv && step_emit;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take  = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        state_q <= state_d;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_q.in_byte  <= in_i.in_byte;
      s1_q.is_final <= in_i.is_final;
    end
    if (out_load) begin
      out_q <= step_res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.code_unit     = out_q.code_unit;
  assign out_o.unit_valid    = out_q.unit_valid;
  assign out_o.end_of_string = out_q.end_of_string;

  // Final byte leaves the decoder in its reset state
  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_q.is_final) |=> (state_q == '0))
    else $error("sequence state not cleared after final byte");

  // A word without a unit can only be the end marker
  a_empty_is_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_q.unit_valid) |-> (out_q.end_of_string && out_q.code_unit == '0))
    else $error("empty result word without end marker");

  // Surrogate code units never leave the block
  a_no_surrogate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.unit_valid) |->
      (out_q.code_unit[15:11] != u8u16_pkg::SurrogateTop))
    else $error("surrogate code unit emitted");

  // Input register is never overwritten while it holds an unfinished byte
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |-> (!s1_valid_q || s1_adv))
    else $error("input register overrun");

  // A pending word is never replaced before it is taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |-> out_room)
    else $error("output register overwritten while stalled");

endmodule
